>>> rtl/qcsv_pkg.sv
// qcsv_pkg: types and constants shared by the quoted csv field splitter
// no dependencies; used by every module under rtl
`timescale 1ns / 1ps
`default_nettype none

package qcsv_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDelimiter  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWrapper    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSkipHeader = 2'd2;

  // register reset values
  localparam logic [7:0] DelimiterReset = 8'd44;
  localparam logic [7:0] WrapperReset   = 8'd34;

  // fixed byte codes
  localparam logic [7:0] ChNewline = 8'd10;
  localparam logic [7:0] ChSpace   = 8'd32;
  localparam logic [7:0] ChTab     = 8'd9;
  localparam logic [7:0] ChCr      = 8'd13;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       field_end;
    logic       record_end;
  } out_item_t;

  // classified item: up to two results, the second is always a record close
  typedef struct packed {
    logic      r0_valid;
    out_item_t r0;
    logic      r1_valid;
  } entry_t;

  localparam out_item_t FieldMark  = '{out_byte: 8'd0, data_valid: 1'b0,
                                       field_end: 1'b1, record_end: 1'b0};
  localparam out_item_t RecordMark = '{out_byte: 8'd0, data_valid: 1'b0,
                                       field_end: 1'b1, record_end: 1'b1};

endpackage

`default_nettype wire

>>> rtl/qcsv_front.sv
// qcsv_front: configuration registers, quote tracking and byte classification
// depends on qcsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module qcsv_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [qcsv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          accept_i,
  input  wire qcsv_pkg::in_item_t            item_i,
  output qcsv_pkg::entry_t                   entry_o,
  output logic                               entry_push_o
);

  logic [7:0] delim_q, wrap_q;
  logic       skip_q;

  logic inside_q, inside_d;
  logic closed_q, closed_d;
  logic hdone_q, hdone_d;
  logic ropen_q, ropen_d;

  logic              hide;
  logic [7:0]        b;
  qcsv_pkg::entry_t  ent;
  qcsv_pkg::out_item_t data_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= qcsv_pkg::DelimiterReset;
      wrap_q  <= qcsv_pkg::WrapperReset;
      skip_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qcsv_pkg::CfgDelimiter:  delim_q <= cfg_data_i;
        qcsv_pkg::CfgWrapper:    wrap_q  <= cfg_data_i;
        qcsv_pkg::CfgSkipHeader: skip_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign b    = item_i.in_byte;
  assign hide = skip_q & ~hdone_q;

  always_comb begin
    data_res = '{out_byte: b, data_valid: 1'b1, field_end: 1'b0, record_end: 1'b0};
    ent      = '0;
    inside_d = inside_q;
    closed_d = closed_q;
    hdone_d  = hdone_q;
    ropen_d  = ropen_q;

    // newline wins over any register value
    priority if (b == qcsv_pkg::ChNewline) begin
      ent.r0_valid = ~hide;
      ent.r0       = qcsv_pkg::RecordMark;
      inside_d     = 1'b0;
      closed_d     = 1'b0;
      ropen_d      = 1'b0;
      hdone_d      = 1'b1;
    end else if (b == wrap_q) begin
      ropen_d = 1'b1;
      if (inside_q) begin
        inside_d = 1'b0;
        closed_d = 1'b1;
      end else begin
        // doubled wrapper gives one literal wrapper
        ent.r0_valid = closed_q & ~hide;
        ent.r0       = data_res;
        inside_d     = 1'b1;
        closed_d     = 1'b0;
      end
    end else begin
      ropen_d  = 1'b1;
      closed_d = 1'b0;
      priority if (inside_q) begin
        ent.r0_valid = ~hide;
        ent.r0       = data_res;
      end else if (b == delim_q) begin
        ent.r0_valid = ~hide;
        ent.r0       = qcsv_pkg::FieldMark;
      end else if (b == qcsv_pkg::ChSpace || b == qcsv_pkg::ChTab ||
                   b == qcsv_pkg::ChCr) begin
        ent.r0_valid = 1'b0;
      end else begin
        ent.r0_valid = ~hide;
        ent.r0       = data_res;
      end
    end

    // end of source closes an open record and restarts the parse
    if (item_i.end_of_source) begin
      ent.r1_valid = ropen_d & ~hide;
      inside_d     = 1'b0;
      closed_d     = 1'b0;
      hdone_d      = 1'b0;
      ropen_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      closed_q <= 1'b0;
      hdone_q  <= 1'b0;
      ropen_q  <= 1'b0;
    end else if (accept_i) begin
      inside_q <= inside_d;
      closed_q <= closed_d;
      hdone_q  <= hdone_d;
      ropen_q  <= ropen_d;
    end
  end

  assign entry_o      = ent;
  assign entry_push_o = accept_i & (ent.r0_valid | ent.r1_valid);

endmodule

`default_nettype wire

>>> rtl/qcsv_queue.sv
// qcsv_queue: short queue of classified entries between front and back
// depends on qcsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module qcsv_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire qcsv_pkg::entry_t entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output qcsv_pkg::entry_t      entry_o,
  output logic                  valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  qcsv_pkg::entry_t store_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign entry_o = store_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/qcsv_back.sv
// qcsv_back: expands each entry into one or two results, one per transfer
// depends on qcsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module qcsv_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire qcsv_pkg::entry_t q_entry_i,
  output logic                  q_pop_o,
  input  wire logic             pop,
  output logic                  empty,
  output qcsv_pkg::out_item_t   out_item_o
);

  qcsv_pkg::entry_t cur_q, cur_d;
  logic pop_acc, last, take;

  assign empty      = ~(cur_q.r0_valid | cur_q.r1_valid);
  assign out_item_o = cur_q.r0_valid ? cur_q.r0 : qcsv_pkg::RecordMark;
  assign pop_acc    = pop & ~empty;
  assign last       = cur_q.r0_valid ^ cur_q.r1_valid;
  // load the next entry when the held one is gone or leaves in this transfer
  assign take       = empty | (pop_acc & last);
  assign q_pop_o    = q_valid_i & take;

  always_comb begin
    cur_d = cur_q;
    if (pop_acc) begin
      if (cur_q.r0_valid) begin
        cur_d.r0_valid = 1'b0;
      end else begin
        cur_d.r1_valid = 1'b0;
      end
    end
    if (q_pop_o) begin
      cur_d = q_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= '0;
    end else begin
      cur_q <= cur_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/quoted_csv_field_splitter.sv
// quoted_csv_field_splitter: top level, front classifier, entry queue, result back end
// depends on qcsv_pkg, qcsv_front, qcsv_queue, qcsv_back
//
//   channel   handshake               payload
//   input     push / full             in_item_i  (in_byte, end_of_source)
//   result    empty / pop             out_item_o (out_byte, data_valid, field_end, record_end)
//   config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// one byte is accepted per cycle while the entry queue has room; the queue is
// QueueDepth entries deep. one result leaves per cycle while pop is high, so a byte that gives two
// results holds the back end until both have left. each entry is registered in the queue and then
// in the back end before its result appears. reset returns the parse and registers to their
// defaults at once; configuration writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module quoted_csv_field_splitter #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire qcsv_pkg::in_item_t           in_item_i,
  output logic                              empty,
  input  wire logic                         pop,
  output qcsv_pkg::out_item_t               out_item_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qcsv_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i
);

  qcsv_pkg::entry_t f_entry, q_entry;
  logic f_push, q_valid, q_pop, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push & ~full;

  qcsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .entry_o      (f_entry),
    .entry_push_o (f_push)
  );

  qcsv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .entry_o (q_entry),
    .valid_o (q_valid)
  );

  qcsv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  // a record close always closes the field too
  a_record_implies_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.record_end |-> out_item_o.field_end)
    else $error("record_end without field_end");

  // a result is either a data byte or a boundary mark
  a_data_or_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.data_valid != out_item_o.field_end))
    else $error("result is neither data nor boundary");

  // boundary marks carry a zero byte
  a_mark_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.data_valid |-> out_item_o.out_byte == 8'd0)
    else $error("boundary mark with non-zero byte");

  // a result held under back-pressure stays put
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> tb/quoted_csv_field_splitter_tb.sv
// quoted_csv_field_splitter_tb: self-checking bench for the csv field splitter
// depends on qcsv_pkg and quoted_csv_field_splitter; a built-in parser model predicts
// every result transfer, with random idling on both queue sides
`timescale 1ns / 1ps

module quoted_csv_field_splitter_tb;

  logic                          clk = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  qcsv_pkg::in_item_t            in_item_i = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  qcsv_pkg::out_item_t           out_item_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [qcsv_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [7:0]                    cfg_data_i = '0;

  quoted_csv_field_splitter uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk = ~clk;

  // source bytes waiting to be pushed, and field results still due
  qcsv_pkg::in_item_t  byte_q[$];
  qcsv_pkg::out_item_t field_q[$];

  // parser copy: format registers and quote/record state
  logic [7:0] delim       = qcsv_pkg::DelimiterReset;
  logic [7:0] quote_ch    = qcsv_pkg::WrapperReset;
  logic       drop_header = 1'b0;
  logic       in_quote    = 1'b0;
  logic       quote_closed = 1'b0;
  logic       header_seen = 1'b0;
  logic       rec_open    = 1'b0;

  int errors = 0;
  int n_queued = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_records = 0;
  int stall_cycles = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;

  function automatic qcsv_pkg::out_item_t data_item(input logic [7:0] b);
    qcsv_pkg::out_item_t r;
    r.out_byte   = b;
    r.data_valid = 1'b1;
    r.field_end  = 1'b0;
    r.record_end = 1'b0;
    return r;
  endfunction

  task automatic append_result(input qcsv_pkg::out_item_t r);
    field_q.insert(field_q.size(), r);
  endtask

  task automatic end_record();
    in_quote     = 1'b0;
    quote_closed = 1'b0;
    rec_open     = 1'b0;
    header_seen  = 1'b1;
  endtask

  // work out the results of one accepted source byte
  task automatic parse_byte(input qcsv_pkg::in_item_t it);
    logic       hide;
    logic [7:0] b;
    hide = drop_header && !header_seen;
    b = it.in_byte;
    if (b == qcsv_pkg::ChNewline) begin
      if (!hide) append_result(qcsv_pkg::RecordMark);
      end_record();
    end else begin
      rec_open = 1'b1;
      if (b == quote_ch) begin
        if (in_quote) begin
          in_quote     = 1'b0;
          quote_closed = 1'b1;
        end else begin
          // doubled wrapper gives one literal wrapper
          if (quote_closed && !hide) append_result(data_item(b));
          in_quote     = 1'b1;
          quote_closed = 1'b0;
        end
      end else begin
        quote_closed = 1'b0;
        if (in_quote) begin
          if (!hide) append_result(data_item(b));
        end else if (b == delim) begin
          if (!hide) append_result(qcsv_pkg::FieldMark);
        end else if (b == qcsv_pkg::ChSpace || b == qcsv_pkg::ChTab ||
                     b == qcsv_pkg::ChCr) begin
          // trimmed outside quotes
        end else if (!hide) begin
          append_result(data_item(b));
        end
      end
    end
    if (it.end_of_source) begin
      if (rec_open) begin
        if (!hide) append_result(qcsv_pkg::RecordMark);
        end_record();
      end
      in_quote     = 1'b0;
      quote_closed = 1'b0;
      header_seen  = 1'b0;
      rec_open     = 1'b0;
    end
  endtask

  // sender side
  always @(negedge clk) begin : tx_side
    logic offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (byte_q.size() != 0) begin
        offer = 1'b1;
        in_item_i <= byte_q[0];
        if (!calm && $urandom_range(0, 11) == 0) tx_gap = $urandom_range(1, 19);
      end
    end
    push <= offer;
  end

  // receiver side; one long hold-off while plenty of bytes are still queued
  always @(negedge clk) begin : rx_side
    logic take;
    take = 1'b0;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && byte_q.size() > 40) begin
        hold_done = 1'b1;
        hold_left = 150;
      end else if (rx_gap > 0) begin
        rx_gap--;
      end else begin
        take = 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 19);
      end
    end
    pop <= take;
  end

  // transfers on both queue sides
  always @(posedge clk) begin : watch
    qcsv_pkg::out_item_t want;
    if (rst_ni) begin
      if (push && full) stall_cycles++;
      if (push && !full) begin
        parse_byte(in_item_i);
        void'(byte_q.pop_front());
        n_bytes++;
      end
      if (pop && !empty) begin
        n_results++;
        if (out_item_o.record_end) n_records++;
        if (field_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result byte=%02h dv=%b fe=%b re=%b", $realtime,
                     out_item_o.out_byte, out_item_o.data_valid, out_item_o.field_end,
                     out_item_o.record_end);
          errors++;
        end else begin
          want = field_q.pop_front();
          if (out_item_o.out_byte !== want.out_byte ||
              out_item_o.data_valid !== want.data_valid ||
              out_item_o.field_end !== want.field_end ||
              out_item_o.record_end !== want.record_end) begin
            if (errors < 10)
              $display({"%0t: mismatch exp byte=%02h dv=%b fe=%b re=%b, ",
                        "got byte=%02h dv=%b fe=%b re=%b"},
                       $realtime, want.out_byte, want.data_valid, want.field_end,
                       want.record_end, out_item_o.out_byte, out_item_o.data_valid,
                       out_item_o.field_end, out_item_o.record_end);
            errors++;
          end
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic eos);
    qcsv_pkg::in_item_t it;
    it.in_byte = b;
    it.end_of_source = eos;
    byte_q.insert(byte_q.size(), it);
    n_queued++;
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = 8'($urandom_range(0, 255));
      1: c = qcsv_pkg::ChSpace;
      2: c = ($urandom_range(0, 1) != 0) ? qcsv_pkg::ChTab : qcsv_pkg::ChCr;
      default: c = 8'($urandom_range(97, 122));
    endcase
    return c;
  endfunction

  // one record of the current format with random field content
  task automatic add_record();
    int fields;
    int len;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) add_byte(delim, 1'b0);
      if ($urandom_range(0, 1) != 0) begin
        if ($urandom_range(0, 3) == 0) add_byte(qcsv_pkg::ChSpace, 1'b0);
        add_byte(quote_ch, 1'b0);
        len = $urandom_range(0, 6);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 7))
            0: add_byte(delim, 1'b0);
            1: begin
              add_byte(quote_ch, 1'b0);
              add_byte(quote_ch, 1'b0);
            end
            default: add_byte(text_char(), 1'b0);
          endcase
        end
        add_byte(quote_ch, 1'b0);
      end else begin
        len = $urandom_range(0, 6);
        for (int k = 0; k < len; k++) add_byte(text_char(), 1'b0);
      end
    end
    case ($urandom_range(0, 9))
      0: add_byte(qcsv_pkg::ChNewline, 1'b1);
      1: add_byte(delim, 1'b1);
      2: add_byte(text_char(), 1'b1);
      default: add_byte(qcsv_pkg::ChNewline, 1'b0);
    endcase
  endtask

  task automatic add_random(input int count);
    int target;
    target = n_queued + count;
    while (n_queued < target) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      else
        add_record();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (byte_q.size() != 0 || field_q.size() != 0);
    // bytes that give no result may still be in flight
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic [qcsv_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      qcsv_pkg::CfgDelimiter:  delim = val;
      qcsv_pkg::CfgWrapper:    quote_ch = val;
      qcsv_pkg::CfgSkipHeader: drop_header = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_format(input logic [7:0] d, input logic [7:0] q, input logic s);
    write_reg(qcsv_pkg::CfgDelimiter, d);
    write_reg(qcsv_pkg::CfgWrapper, q);
    write_reg(qcsv_pkg::CfgSkipHeader, {7'd0, s});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: plain and quoted fields, doubled quote, trimming, empty line,
    // newline inside quotes, trailing delimiter and open quote at end of source
    add_byte("a", 1'b0);
    add_byte(",", 1'b0);
    add_byte("\"", 1'b0);
    add_byte(",", 1'b0);
    add_byte("\"", 1'b0);
    add_byte("\"", 1'b0);
    add_byte("\"", 1'b0);
    add_byte(qcsv_pkg::ChSpace, 1'b0);
    add_byte("q", 1'b0);
    add_byte(qcsv_pkg::ChTab, 1'b0);
    add_byte(qcsv_pkg::ChCr, 1'b0);
    add_byte(qcsv_pkg::ChNewline, 1'b0);
    add_byte(qcsv_pkg::ChNewline, 1'b0);
    add_byte("\"", 1'b0);
    add_byte(",", 1'b0);
    add_byte(qcsv_pkg::ChNewline, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(",", 1'b1);
    add_byte("\"", 1'b0);
    add_byte("z", 1'b1);
    add_byte(8'hff, 1'b1);
    wait_drained();

    // extreme byte values with the header dropped
    set_format(8'h00, 8'hff, 1'b1);
    add_random(155);
    wait_drained();

    // newline as delimiter, space as wrapper
    set_format(qcsv_pkg::ChNewline, qcsv_pkg::ChSpace, 1'b0);
    add_random(155);
    wait_drained();

    // wrapper equal to delimiter
    set_format("|", "|", 1'b1);
    add_random(155);
    wait_drained();

    // space as delimiter, newline as wrapper
    set_format(qcsv_pkg::ChSpace, qcsv_pkg::ChNewline, 1'b0);
    add_random(155);
    wait_drained();

    set_format(8'hff, 8'h00, 1'b1);
    add_random(155);
    wait_drained();

    // closing stretch at full rate
    set_format(",", "\"", 1'b0);
    calm = 1'b1;
    add_random(155);
    wait_drained();

    if (field_q.size() != 0) errors++;
    $display("%0d source bytes pushed, %0d result transfers checked (%0d records)",
             n_bytes, n_results, n_records);
    $display("6 register settings, %0d cycles with the input stalled by a full queue",
             stall_cycles);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
